// File: rtl/nbe_pkg.sv
// shared types and constants for the normalized byte entropy unit
package nbe_pkg;

    localparam int MaxBytes    = 65536;
    localparam int LogFracBits = 16;
    localparam int CntW        = 17;
    localparam int BinW        = 8;
    localparam int Bins        = 256;
    localparam int LogW        = 5 + LogFracBits;
    localparam int ProdW       = CntW + LogW;
    localparam int AccW        = ProdW + BinW;
    // the divisor is n << (LogFracBits + 3 - 16)
    localparam int DivShift    = LogFracBits + 3 - 16;
    localparam int QuoW        = 20;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_COUNT_RD,
        ST_COUNT_WR,
        ST_WALK_RD,
        ST_WALK_LOG,
        ST_WALK_MUL,
        ST_WALK_ACC,
        ST_TOT_LOG,
        ST_TOT_MUL,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic clear_all;
        logic clear_wr;
        logic count_rd;
        logic count_wr;
        logic walk_rd;
        logic log_start;
        logic log_of_total;
        logic mul_bin;
        logic acc_bin;
        logic mul_total;
        logic div_start;
        logic bin_inc;
        logic done_clear;
    } cmd_t;

    typedef struct packed {
        logic bin_last;
        logic log_done;
        logic div_done;
    } sts_t;

endpackage

// File: rtl/nbe_ram.sv
// generic single port ram with registered read
module nbe_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: rtl/nbe_log2.sv
// iterative log2 by repeated squaring, one fraction bit per cycle
module nbe_log2 (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [nbe_pkg::CntW-1:0]      x,
    output logic                          done,
    output logic [nbe_pkg::LogW-1:0]      result
);
    logic [4:0]  exp_reg, exp_next;
    logic [32:0] m_reg, m_next;
    logic [nbe_pkg::LogFracBits-1:0] frac_reg, frac_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [4:0]  lead;
    logic [65:0] sq;
    logic [33:0] msq;

    always_comb begin
        lead = '0;
        for (int i = 0; i < nbe_pkg::CntW; i++) begin
            if (x[i]) lead = 5'(i);
        end
    end

    assign sq  = m_reg * m_reg;
    assign msq = sq[64:31];

    always_comb begin
        exp_next  = exp_reg;
        m_next    = m_reg;
        frac_next = frac_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            exp_next  = lead;
            m_next    = 33'({16'd0, x} << (5'd31 - lead));
            frac_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (msq[32]) begin
                m_next = msq[33:1];
            end else begin
                m_next = msq[32:0];
            end
            frac_next = {frac_reg[nbe_pkg::LogFracBits-2:0], msq[32]};
            cnt_next  = cnt_reg + 5'd1;
            if (cnt_reg == 5'(nbe_pkg::LogFracBits - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        exp_reg  <= exp_next;
        m_reg    <= m_next;
        frac_reg <= frac_next;
        cnt_reg  <= cnt_next;
    end

    assign done   = !busy_reg && !start;
    assign result = {exp_reg, frac_reg};
endmodule

// File: rtl/nbe_datapath.sv
// histogram memory, counter, log, multiply-accumulate and divider
module nbe_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  nbe_pkg::cmd_t                 cmd,
    output nbe_pkg::sts_t                 sts,
    input  logic [7:0]                    s_data_byte,
    output logic [16:0]                   m_entropy_frac,
    output logic [16:0]                   m_byte_total,
    output logic                          m_overflow
);
    logic [nbe_pkg::BinW-1:0] bin_reg, bin_next;
    logic [nbe_pkg::BinW-1:0] byte_reg;
    logic [nbe_pkg::CntW-1:0] n_reg, n_next;
    logic                     ovf_reg, ovf_next;
    logic                     ram_we;
    logic [nbe_pkg::BinW-1:0] ram_addr;
    logic [nbe_pkg::CntW-1:0] ram_wdata, ram_rdata;
    logic [nbe_pkg::CntW-1:0] bin_cnt_reg;
    logic [nbe_pkg::CntW-1:0] log_x;
    logic                     log_done;
    logic [nbe_pkg::LogW-1:0] log_res;
    logic [nbe_pkg::ProdW-1:0] prod_reg;
    logic [nbe_pkg::AccW-1:0]  acc_reg;
    logic [nbe_pkg::AccW-1:0]  rem_reg;
    logic [nbe_pkg::AccW-1:0]  div_reg;
    logic [nbe_pkg::QuoW-1:0]  dvd_reg;
    logic [nbe_pkg::QuoW-1:0]  quo_reg;
    logic [5:0]                dcnt_reg;
    logic                      dbusy_reg;
    logic [nbe_pkg::AccW-1:0]  dvd;
    logic [nbe_pkg::AccW:0]    trial;
    logic                      counting;

    assign counting = n_reg < nbe_pkg::CntW'(nbe_pkg::MaxBytes);

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = bin_reg;
        ram_wdata = '0;
        if (cmd.clear_wr) begin
            ram_we = 1'b1;
        end else if (cmd.count_rd) begin
            ram_addr = s_data_byte;
        end else if (cmd.count_wr) begin
            ram_addr  = byte_reg;
            ram_we    = counting;
            ram_wdata = ram_rdata + 1'b1;
        end else if (cmd.walk_rd) begin
            ram_addr = bin_reg;
        end
    end

    nbe_ram #(.Width(nbe_pkg::CntW), .Depth(nbe_pkg::Bins)) u_hist (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb begin
        bin_next = bin_reg;
        n_next   = n_reg;
        ovf_next = ovf_reg;
        if (cmd.clear_all || cmd.done_clear) begin
            bin_next = '0;
        end else if (cmd.bin_inc || cmd.clear_wr) begin
            bin_next = bin_reg + 1'b1;
        end
        if (cmd.count_wr) begin
            if (counting) n_next = n_reg + 1'b1;
            else          ovf_next = 1'b1;
        end
        if (cmd.done_clear) begin
            n_next   = '0;
            ovf_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_reg <= '0;
            n_reg   <= '0;
            ovf_reg <= 1'b0;
        end else begin
            bin_reg <= bin_next;
            n_reg   <= n_next;
            ovf_reg <= ovf_next;
        end
        if (cmd.count_rd) byte_reg <= s_data_byte;
    end

    assign log_x = cmd.log_of_total ? n_reg : ram_rdata;

    nbe_log2 u_log (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.log_start),
        .x       (log_x),
        .done    (log_done),
        .result  (log_res)
    );

    // bin count held across the log iteration
    always_ff @(posedge aclk) begin
        if (cmd.log_start) bin_cnt_reg <= log_x;
        if (cmd.mul_bin || cmd.mul_total) prod_reg <= bin_cnt_reg * log_res;
        if (cmd.clear_all) acc_reg <= '0;
        else if (cmd.acc_bin && bin_cnt_reg != '0)
            acc_reg <= acc_reg + nbe_pkg::AccW'(prod_reg);
    end

    // dividend d = n*log2(n) - sum of c*log2(c), floored at zero
    assign dvd = (nbe_pkg::AccW'(prod_reg) >= acc_reg)
               ? nbe_pkg::AccW'(prod_reg) - acc_reg : '0;

    // restoring divider, one quotient bit per cycle
    assign trial = {rem_reg, dvd_reg[nbe_pkg::QuoW-1]} - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg <= 1'b0;
        end else if (cmd.div_start) begin
            dbusy_reg <= 1'b1;
        end else if (dbusy_reg && dcnt_reg == 6'(nbe_pkg::QuoW - 1)) begin
            dbusy_reg <= 1'b0;
        end
        if (cmd.div_start) begin
            // upper dividend bits start as the remainder, the low QuoW bits shift in
            rem_reg  <= dvd >> nbe_pkg::QuoW;
            dvd_reg  <= dvd[nbe_pkg::QuoW-1:0];
            div_reg  <= nbe_pkg::AccW'(n_reg) << nbe_pkg::DivShift;
            quo_reg  <= '0;
            dcnt_reg <= '0;
        end else if (dbusy_reg) begin
            if (!trial[nbe_pkg::AccW]) begin
                rem_reg <= trial[nbe_pkg::AccW-1:0];
                quo_reg <= {quo_reg[nbe_pkg::QuoW-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[nbe_pkg::AccW-2:0], dvd_reg[nbe_pkg::QuoW-1]};
                quo_reg <= {quo_reg[nbe_pkg::QuoW-2:0], 1'b0};
            end
            dvd_reg  <= {dvd_reg[nbe_pkg::QuoW-2:0], 1'b0};
            dcnt_reg <= dcnt_reg + 6'd1;
        end
    end

    assign sts.bin_last = bin_reg == '1;
    assign sts.log_done = log_done;
    assign sts.div_done = !dbusy_reg && !cmd.div_start;

    assign m_entropy_frac = (quo_reg > nbe_pkg::QuoW'(65536)) ? 17'd65536 : quo_reg[16:0];
    assign m_byte_total   = n_reg;
    assign m_overflow     = ovf_reg;
endmodule

// File: rtl/nbe_ctrl.sv
// sequencer for counting, entropy walk, division and histogram clear
module nbe_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          s_last,
    output logic          m_valid,
    input  logic          m_ready,
    output nbe_pkg::cmd_t cmd,
    input  nbe_pkg::sts_t sts
);
    nbe_pkg::state_t state_reg, state_next;
    logic last_reg, last_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nbe_pkg::ST_CLEAR;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            nbe_pkg::ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (sts.bin_last) state_next = nbe_pkg::ST_COUNT_RD;
            end
            nbe_pkg::ST_COUNT_RD: begin
                s_ready      = 1'b1;
                cmd.count_rd = 1'b1;
                if (s_valid) begin
                    last_next  = s_last;
                    state_next = nbe_pkg::ST_COUNT_WR;
                end
            end
            nbe_pkg::ST_COUNT_WR: begin
                cmd.count_wr = 1'b1;
                if (last_reg) begin
                    cmd.clear_all = 1'b1;
                    state_next    = nbe_pkg::ST_WALK_RD;
                end else begin
                    state_next = nbe_pkg::ST_COUNT_RD;
                end
            end
            nbe_pkg::ST_WALK_RD: begin
                cmd.walk_rd = 1'b1;
                state_next  = nbe_pkg::ST_WALK_LOG;
            end
            nbe_pkg::ST_WALK_LOG: begin
                cmd.log_start = 1'b1;
                state_next    = nbe_pkg::ST_WALK_MUL;
            end
            nbe_pkg::ST_WALK_MUL: begin
                if (sts.log_done) begin
                    cmd.mul_bin = 1'b1;
                    state_next  = nbe_pkg::ST_WALK_ACC;
                end
            end
            nbe_pkg::ST_WALK_ACC: begin
                cmd.acc_bin = 1'b1;
                cmd.bin_inc = 1'b1;
                state_next  = sts.bin_last ? nbe_pkg::ST_TOT_LOG : nbe_pkg::ST_WALK_RD;
            end
            nbe_pkg::ST_TOT_LOG: begin
                cmd.log_start    = 1'b1;
                cmd.log_of_total = 1'b1;
                state_next       = nbe_pkg::ST_TOT_MUL;
            end
            nbe_pkg::ST_TOT_MUL: begin
                if (sts.log_done) begin
                    cmd.mul_total = 1'b1;
                    state_next    = nbe_pkg::ST_DIV;
                end
            end
            nbe_pkg::ST_DIV: begin
                cmd.div_start = 1'b1;
                state_next    = nbe_pkg::ST_OUT;
            end
            nbe_pkg::ST_OUT: begin
                if (sts.div_done) begin
                    m_valid = 1'b1;
                    if (m_ready) begin
                        cmd.done_clear = 1'b1;
                        state_next     = nbe_pkg::ST_CLEAR;
                    end
                end
            end
            default: state_next = nbe_pkg::ST_CLEAR;
        endcase
    end
endmodule

// File: rtl/normalized_byte_entropy_unit.sv
// normalized byte entropy unit top level
// Counts bytes one at a time into a 256-bin histogram held in a
// single-port memory (read then increment). After the item flagged last, the
// unit walks all 256 bins, computing each log2 with an iterative squaring unit,
// then divides with a restoring divider that yields a 20-bit quotient. The
// result is held until taken; then a clearing pass over all 256 bins runs
// (also after reset) before the next item is accepted.
module normalized_byte_entropy_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [16:0] m_entropy_frac,
    output logic [16:0] m_byte_total,
    output logic        m_overflow
);
    nbe_pkg::cmd_t cmd;
    nbe_pkg::sts_t sts;

    nbe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_last  (s_last),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    nbe_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_data_byte    (s_data_byte),
        .m_entropy_frac (m_entropy_frac),
        .m_byte_total   (m_byte_total),
        .m_overflow     (m_overflow)
    );

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input and result active together");
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_entropy_frac))
        else $error("result dropped");
    a_frac_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_entropy_frac <= 17'd65536) else $error("entropy above one");
endmodule
